### design/hlv_pkg.sv
// Shared types, constants and the quarter-wave sine table of the Hough line accumulator.
package hlv_pkg;

    localparam int NUM_ANGLES = 180;
    localparam int COUNT_W    = 19;
    localparam int COEF_W     = 15;
    localparam int COEF_FRAC  = 14;
    localparam int PROD_W     = 24;
    localparam int SUM_W      = 26;
    localparam int TRUNC_W    = SUM_W - COEF_FRAC;
    localparam int SINE_IDX_W = 7;
    localparam int QUARTER    = 90;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [COEF_W-1:0] SINE_Q14 [0:QUARTER] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    typedef enum logic [1:0] {
        OP_VOTE  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOTE,
        ST_QROW,
        ST_QSCAN,
        ST_QOUT
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [9:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [4:0]  region_angle;
        logic [3:0]  region_rho;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         peak_angle;
        logic [11:0]        peak_rho_index;
        logic [COUNT_W-1:0] peak_count;
        logic               above_threshold;
    } t_out_item;

endpackage

### design/hough_line_vote_peak_regions_top.sv
// Top level of the Hough line accumulator with region peak search.
//
// Input channel (i_in_valid, o_in_stall, i_in_item) carries one item: a vote for an
// edge pixel, a region peak query, or a clear of the accumulator. The block takes
// one item at a time and holds o_in_stall high until that item is finished.
// For a vote, a single shared multiplier forms x*cos and then y*sin for each
// angle, and the resulting bin is updated by a pipelined read-modify-write of
// the one accumulator memory. A query sets up its row base in ST_QROW, then
// scans REGION_ANGLES*REGION_BINS bins, one memory read per cycle. A clear
// sweeps the whole memory, 180*2*(IMG_WIDTH+IMG_HEIGHT) words (403200 at the
// default size).
// Only a query returns an item on the output channel (o_out_valid, i_out_stall,
// o_out_item). The result sits in an output register, so a new item is accepted
// while it waits; a later query holds its result until the receiver takes the old
// one. After reset the same clearing sweep runs before the first item is accepted;
// the threshold register returns to 100 and may be written through i_cfg_we at any
// time the block is idle.
module hough_line_vote_peak_regions_top
    import hlv_pkg::*;
#(
    parameter int IMG_WIDTH     = 640,
    parameter int IMG_HEIGHT    = 480,
    parameter int REGION_ANGLES = 10,
    parameter int REGION_BINS   = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int RHO_HALF = IMG_WIDTH + IMG_HEIGHT;
    localparam int NUM_RHO  = 2 * RHO_HALF;
    localparam int RHO_W    = $clog2(NUM_RHO);
    localparam int DEPTH    = NUM_ANGLES * NUM_RHO;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int BIN_W    = ((RHO_W > TRUNC_W) ? RHO_W : TRUNC_W) + 2;
    localparam int QA_W     = 5 + $clog2(REGION_ANGLES + 1);
    localparam int QR_W     = 4 + $clog2(REGION_BINS + 1);
    localparam int QDA_W    = $clog2(REGION_ANGLES + 1);
    localparam int QDR_W    = $clog2(REGION_BINS + 1);

    // Control
    t_state r_state, n_state;
    logic   s_accept;
    logic   s_in_image;
    logic   s_vote_done;
    logic   s_scan_done;
    logic   s_out_free;

    // Accumulator memory
    logic [COUNT_W-1:0] r_acc_mem [0:DEPTH-1];
    logic [COUNT_W-1:0] r_mem_q;
    logic               s_we;
    logic [ADDR_W-1:0]  s_wa;
    logic [COUNT_W-1:0] s_wd;
    logic [ADDR_W-1:0]  s_ra;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Vote pipeline
    logic [9:0]              r_px;
    logic [8:0]              r_py;
    logic [7:0]              r_ang;
    logic                    r_ph;
    logic                    r_issue;
    logic [SINE_IDX_W-1:0]   s_coef_idx;
    logic [COEF_W-1:0]       s_coef;
    logic [9:0]              s_mul_a;
    logic [PROD_W:0]         s_prod;
    logic [PROD_W-1:0]       r_mul;
    logic                    r_mul_v;
    logic                    r_mul_ph;
    logic                    r_mul_neg;
    logic signed [SUM_W-1:0] r_part;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_sum_v;
    logic [SUM_W-1:0]        s_sum_mag;
    logic [TRUNC_W-1:0]      s_tq;
    logic signed [BIN_W-1:0] s_trunc;
    logic signed [BIN_W-1:0] s_bin;
    logic signed [BIN_W-1:0] r_bin;
    logic                    r_bin_v;
    logic                    s_bin_ok;
    logic [ADDR_W-1:0]       r_row;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_rd_v;
    logic [ADDR_W-1:0]       r_wb_addr;
    logic                    r_wb_v;

    // Query scan
    logic [QA_W-1:0]    r_qa;
    logic [QR_W-1:0]    r_qr;
    logic [QR_W-1:0]    r_qr0;
    logic [QDA_W-1:0]   r_qda;
    logic [QDR_W-1:0]   r_qdr;
    logic [ADDR_W-1:0]  r_qrow;
    logic               r_qgen;
    logic               s_qelem_ok;
    logic               r_qv1;
    logic [7:0]         r_qa1;
    logic [11:0]        r_qr1;
    logic [COUNT_W-1:0] r_best;
    logic [7:0]         r_best_a;
    logic [11:0]        r_best_r;

    // Output and configuration
    logic               r_out_v;
    t_out_item          r_out_item;
    logic [COUNT_W-1:0] r_thresh;

    assign s_accept    = i_in_valid && !o_in_stall;
    assign s_in_image  = (32'(i_in_item.pixel_x) < IMG_WIDTH) &&
                         (32'(i_in_item.pixel_y) < IMG_HEIGHT);
    assign s_vote_done = !r_issue && !r_mul_v && !r_sum_v && !r_bin_v && !r_rd_v && !r_wb_v;
    assign s_scan_done = !r_qgen && !r_qv1;
    assign s_out_free  = !r_out_v || !i_out_stall;

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (i_in_item.op)
                        OP_VOTE:  n_state = s_in_image ? ST_VOTE : ST_IDLE;
                        OP_QUERY: n_state = ST_QROW;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_VOTE: begin
                if (s_vote_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QROW: n_state = ST_QSCAN;
            ST_QSCAN: begin
                if (s_scan_done) begin
                    n_state = ST_QOUT;
                end
            end
            ST_QOUT: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: input stall and the memory port controls
    always_comb begin
        o_in_stall = 1'b1;
        s_we       = 1'b0;
        s_wa       = r_wb_addr;
        s_wd       = (r_mem_q == COUNT_MAX) ? COUNT_MAX : r_mem_q + 1'b1;
        s_ra       = r_addr;
        unique case (r_state)
            ST_CLEAR: begin
                s_we = 1'b1;
                s_wa = r_clr_addr;
                s_wd = '0;
            end
            ST_IDLE:  o_in_stall = 1'b0;
            ST_VOTE:  s_we = r_wb_v;
            ST_QROW:  s_ra = r_addr;
            ST_QSCAN: s_ra = r_qrow + ADDR_W'(r_qr);
            ST_QOUT:  s_ra = r_addr;
            default:  o_in_stall = 1'b1;
        endcase
    end

    // Coefficient selection for the shared multiplier. Phase 0 forms x*|cos|,
    // phase 1 forms y*sin; cosine is negative past 90 degrees.
    always_comb begin
        if (!r_ph) begin
            s_coef_idx = (r_ang <= 8'(QUARTER)) ? SINE_IDX_W'(8'(QUARTER) - r_ang)
                                                : SINE_IDX_W'(r_ang - 8'(QUARTER));
            s_mul_a    = r_px;
        end else begin
            s_coef_idx = (r_ang <= 8'(QUARTER)) ? SINE_IDX_W'(r_ang)
                                                : SINE_IDX_W'(8'(2 * QUARTER) - r_ang);
            s_mul_a    = 10'(r_py);
        end
        s_coef = SINE_Q14[s_coef_idx];
        s_prod = s_mul_a * s_coef;
    end

    // Truncation toward zero of the Q14 sum, then offset into the bin range.
    always_comb begin
        s_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        s_tq      = s_sum_mag[SUM_W-1:COEF_FRAC];
        s_trunc   = r_sum[SUM_W-1] ? -$signed(BIN_W'(s_tq)) : $signed(BIN_W'(s_tq));
        s_bin     = s_trunc + $signed(BIN_W'(RHO_HALF));
        s_bin_ok  = !r_bin[BIN_W-1] && ($unsigned(r_bin) < BIN_W'(NUM_RHO));
    end

    assign s_qelem_ok = (32'(r_qa) < NUM_ANGLES) && (32'(r_qr) < NUM_RHO);

    // Accumulator memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_acc_mem[s_wa] <= s_wd;
        end
        r_mem_q <= r_acc_mem[s_ra];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_issue    <= 1'b0;
            r_mul_v    <= 1'b0;
            r_sum_v    <= 1'b0;
            r_bin_v    <= 1'b0;
            r_rd_v     <= 1'b0;
            r_wb_v     <= 1'b0;
            r_qgen     <= 1'b0;
            r_qv1      <= 1'b0;
            r_out_v    <= 1'b0;
            r_thresh   <= COUNT_W'(100);
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else if (s_accept && i_in_item.op == OP_CLEAR) begin
                r_clr_addr <= '0;
            end

            // Vote pipeline valid bits
            if (s_accept && i_in_item.op == OP_VOTE && s_in_image) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_ph && r_ang == 8'(NUM_ANGLES - 1)) begin
                r_issue <= 1'b0;
            end
            r_mul_v <= r_issue;
            r_sum_v <= r_mul_v && r_mul_ph;
            r_bin_v <= r_sum_v;
            r_rd_v  <= r_bin_v && s_bin_ok;
            r_wb_v  <= r_rd_v;

            // Query scan valid bits
            if (r_state == ST_QROW) begin
                r_qgen <= 1'b1;
            end else if (r_qgen && r_qdr == QDR_W'(REGION_BINS - 1) &&
                         r_qda == QDA_W'(REGION_ANGLES - 1)) begin
                r_qgen <= 1'b0;
            end
            r_qv1 <= r_qgen && s_qelem_ok;

            if (r_state == ST_QOUT && s_out_free) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Vote: sequencing over angles and phases
        if (s_accept && i_in_item.op == OP_VOTE) begin
            r_px  <= i_in_item.pixel_x;
            r_py  <= i_in_item.pixel_y;
            r_ang <= '0;
            r_ph  <= 1'b0;
            r_row <= '0;
        end else begin
            if (r_issue) begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    r_ang <= r_ang + 1'b1;
                end
            end
            if (r_bin_v) begin
                r_row <= r_row + ADDR_W'(NUM_RHO);
            end
        end

        r_mul     <= s_prod[PROD_W-1:0];
        r_mul_ph  <= r_ph;
        r_mul_neg <= !r_ph && (r_ang > 8'(QUARTER));

        if (r_mul_v && !r_mul_ph) begin
            r_part <= r_mul_neg ? -$signed(SUM_W'(r_mul)) : $signed(SUM_W'(r_mul));
        end
        if (r_mul_v && r_mul_ph) begin
            r_sum <= r_part + $signed(SUM_W'(r_mul));
        end

        r_bin     <= s_bin;
        r_addr    <= r_row + ADDR_W'(r_bin[RHO_W-1:0]);
        r_wb_addr <= r_addr;

        // Query: region origin, row base, then one bin per cycle
        if (s_accept && i_in_item.op == OP_QUERY) begin
            r_qa     <= QA_W'(QA_W'(i_in_item.region_angle) * QA_W'(REGION_ANGLES));
            r_qr     <= QR_W'(QR_W'(i_in_item.region_rho) * QR_W'(REGION_BINS));
            r_qr0    <= QR_W'(QR_W'(i_in_item.region_rho) * QR_W'(REGION_BINS));
            r_qda    <= '0;
            r_qdr    <= '0;
            r_best   <= '0;
            r_best_a <= '0;
            r_best_r <= '0;
        end else begin
            if (r_state == ST_QROW) begin
                r_qrow <= ADDR_W'(ADDR_W'(r_qa) * ADDR_W'(NUM_RHO));
            end else if (r_qgen) begin
                if (r_qdr == QDR_W'(REGION_BINS - 1)) begin
                    r_qdr  <= '0;
                    r_qr   <= r_qr0;
                    r_qda  <= r_qda + 1'b1;
                    r_qa   <= r_qa + 1'b1;
                    r_qrow <= r_qrow + ADDR_W'(NUM_RHO);
                end else begin
                    r_qdr <= r_qdr + 1'b1;
                    r_qr  <= r_qr + 1'b1;
                end
            end
            // Only a strictly larger count replaces the best so far.
            if (r_qv1 && r_mem_q > r_best) begin
                r_best   <= r_mem_q;
                r_best_a <= r_qa1;
                r_best_r <= r_qr1;
            end
        end
        r_qa1 <= 8'(r_qa);
        r_qr1 <= 12'(r_qr);

        if (r_state == ST_QOUT && s_out_free) begin
            r_out_item.peak_angle      <= r_best_a;
            r_out_item.peak_rho_index  <= r_best_r;
            r_out_item.peak_count      <= r_best;
            r_out_item.above_threshold <= r_best > r_thresh;
        end
    end

endmodule

### tb/sv/tb_hough_line_vote_peak_regions_top.sv
// Self-checking testbench of the Hough line accumulator with region peak search.
`timescale 1ns / 1ps

module tb_hough_line_vote_peak_regions_top;
    import hlv_pkg::*;

    // Block size as instantiated. These are the default sizes of the block.
    localparam int IMG_W         = 640;
    localparam int IMG_H         = 480;
    localparam int REGION_ANGLES = 10;
    localparam int REGION_BINS   = 200;
    localparam int RHO_HALF      = IMG_W + IMG_H;
    localparam int RHO_SPAN      = 2 * RHO_HALF;
    localparam int BIN_TOTAL     = NUM_ANGLES * RHO_SPAN;

    // Every value of the two op bits is used by the block except this one, which is ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [COUNT_W-1:0] THRESH_RESET = 19'd100;
    localparam logic [COUNT_W-1:0] THRESH_TOP   = 19'd307200;

    // Random idling, the receiver hold-off and the stretches without idling.
    localparam int IDLE_PCT       = 14;
    localparam int HOLD_AT        = 20;
    localparam int HOLD_CYCLES    = 12000;
    localparam int SEND_CALM_LO   = 350;
    localparam int SEND_CALM_HI   = 460;
    localparam int RECV_CALM_LO   = 40;
    localparam int RECV_CALM_HI   = 55;

    // A clear sweep (and the sweep after reset) moves no item while it runs, so the
    // watchdog allows several of those sweeps.
    localparam int VOTE_SETTLE    = 400;
    localparam int END_SETTLE     = 2500;
    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int REPORT_LIMIT   = 10;

    localparam real PI = 3.14159265358979;

    // Quarter-wave sine in Q2.14: entry k is round(16384 * sin(k degrees)).
    localparam int QUARTER_SINE [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    // Every input of the block has a known value from time zero.
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_item  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_item;
    logic                cfg_we   = 1'b0;
    logic [COUNT_W-1:0]  cfg_data = '0;

    // Items waiting to be offered, and peak results waiting to be seen.
    t_in_item  pending_items [$];
    t_out_item expected_peaks [$];

    // Model of the block: its vote counts and its threshold register.
    bit [COUNT_W-1:0]   vote_bins [0:BIN_TOTAL-1];
    logic [COUNT_W-1:0] threshold_now = THRESH_RESET;

    logic in_taken      = 1'b0;
    int   items_queued  = 0;
    int   items_taken   = 0;
    int   results_seen  = 0;
    int   bad_results   = 0;
    int   quiet_cycles  = 0;
    int   hold_left     = 0;
    bit   hold_used     = 1'b0;

    hough_line_vote_peak_regions_top #(
        .IMG_WIDTH     (IMG_W),
        .IMG_HEIGHT    (IMG_H),
        .REGION_ANGLES (REGION_ANGLES),
        .REGION_BINS   (REGION_BINS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Cosine and sine of a whole-degree angle in 0..179, folded onto the table.
    function automatic int cos_q14(input int deg);
        if (deg <= 90)
            return QUARTER_SINE[90 - deg];
        return -QUARTER_SINE[deg - 90];
    endfunction

    function automatic int sin_q14(input int deg);
        if (deg <= 90)
            return QUARTER_SINE[deg];
        return QUARTER_SINE[180 - deg];
    endfunction

    // One vote per angle. SystemVerilog integer division truncates toward zero,
    // which is the rounding that the block applies to the Q14 product sum.
    function automatic void cast_votes(input logic [9:0] px, input logic [8:0] py);
        longint prod;
        longint bin;
        int     idx;
        if (px >= IMG_W || py >= IMG_H)
            return;
        for (int deg = 0; deg < NUM_ANGLES; deg++) begin
            prod = longint'(px) * cos_q14(deg) + longint'(py) * sin_q14(deg);
            bin  = prod / 16384 + RHO_HALF;
            if (bin < 0 || bin >= RHO_SPAN)
                continue;
            idx = deg * RHO_SPAN + int'(bin);
            if (vote_bins[idx] != {COUNT_W{1'b1}})
                vote_bins[idx] = vote_bins[idx] + 1'b1;
        end
    endfunction

    // Angles outer, rho bins inner, both rising; only a strictly greater count
    // replaces the best so far, so ties keep the earliest bin.
    function automatic t_out_item scan_region(input logic [4:0] ra, input logic [3:0] rr);
        t_out_item        peak;
        bit [COUNT_W-1:0] best;
        int               best_deg;
        int               best_bin;
        int               deg;
        int               bin;
        best     = '0;
        best_deg = 0;
        best_bin = 0;
        for (int da = 0; da < REGION_ANGLES; da++) begin
            deg = int'(ra) * REGION_ANGLES + da;
            if (deg >= NUM_ANGLES)
                continue;
            for (int dr = 0; dr < REGION_BINS; dr++) begin
                bin = int'(rr) * REGION_BINS + dr;
                if (bin >= RHO_SPAN)
                    continue;
                if (vote_bins[deg * RHO_SPAN + bin] > best) begin
                    best     = vote_bins[deg * RHO_SPAN + bin];
                    best_deg = deg;
                    best_bin = bin;
                end
            end
        end
        peak.peak_angle      = best_deg[7:0];
        peak.peak_rho_index  = best_bin[11:0];
        peak.peak_count      = best;
        peak.above_threshold = (best > threshold_now);
        return peak;
    endfunction

    function automatic void apply_item(input t_in_item it);
        case (it.op)
            OP_VOTE:  cast_votes(it.pixel_x, it.pixel_y);
            OP_QUERY: begin
                expected_peaks = {expected_peaks,
                                  scan_region(it.region_angle, it.region_rho)};
            end
            OP_CLEAR: begin
                foreach (vote_bins[i])
                    vote_bins[i] = '0;
            end
            default:  ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued items at the falling edge. A new item (or an
    // idle cycle) is chosen only when nothing is on offer or the last item was
    // taken, so valid never drops while stalled and a stalled item stays put.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_items.size() != 0 &&
                ((items_taken >= SEND_CALM_LO && items_taken < SEND_CALM_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random, except for one long hold-off that lets a result sit
    // in the output register while the next query finishes behind it, so the
    // block has to stall its input, and a stretch with no stall at all.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_used && results_seen >= HOLD_AT) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (results_seen >= RECV_CALM_LO && results_seen < RECV_CALM_HI) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge, updates the model on
    // every accepted item, checks every accepted result against the oldest
    // expected peak, and runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor_p
        t_out_item want;
        in_taken <= in_valid && !in_stall;
        if (rst_n) begin
            if (cfg_we)
                threshold_now = cfg_data;
            if (in_valid && !in_stall) begin
                apply_item(in_item);
                items_taken++;
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_peaks.size() == 0) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                        $display("%0t: unexpected peak: angle %0d rho %0d count %0d above %0b",
                                 $realtime, out_item.peak_angle, out_item.peak_rho_index,
                                 out_item.peak_count, out_item.above_threshold);
                end else begin
                    want = expected_peaks.pop_front();
                    if (out_item.peak_angle !== want.peak_angle ||
                        out_item.peak_rho_index !== want.peak_rho_index ||
                        out_item.peak_count !== want.peak_count ||
                        out_item.above_threshold !== want.above_threshold) begin
                        bad_results++;
                        if (bad_results <= REPORT_LIMIT) begin
                            $display("%0t: peak mismatch: expected angle %0d rho %0d %s",
                                     $realtime, want.peak_angle, want.peak_rho_index,
                                     $sformatf("count %0d above %0b", want.peak_count,
                                               want.above_threshold));
                            $display("    got angle %0d rho %0d count %0d above %0b",
                                     out_item.peak_angle, out_item.peak_rho_index,
                                     out_item.peak_count, out_item.above_threshold);
                        end
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fields that the op does not use are random, so every bit of them moves.
    function automatic t_in_item random_item(input t_op op);
        t_in_item it;
        it.op           = op;
        it.pixel_x      = 10'($urandom_range(0, 1023));
        it.pixel_y      = 9'($urandom_range(0, 511));
        it.region_angle = 5'($urandom_range(0, 31));
        it.region_rho   = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic queue_item(input t_in_item it);
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    task automatic queue_vote(input int px, input int py);
        t_in_item it;
        it         = random_item(OP_VOTE);
        it.pixel_x = px[9:0];
        it.pixel_y = py[8:0];
        queue_item(it);
    endtask

    task automatic queue_query(input int ra, input int rr);
        t_in_item it;
        it              = random_item(OP_QUERY);
        it.region_angle = ra[4:0];
        it.region_rho   = rr[3:0];
        queue_item(it);
    endtask

    // Edge pixels along one straight line through a random point, then a query
    // of the region where that line's peak should sit.
    task automatic queue_line_burst();
        int  deg;
        int  x0;
        int  y0;
        int  npts;
        int  pitch;
        int  t;
        int  px;
        int  py;
        real c;
        real s;
        real rho;
        deg   = $urandom_range(0, NUM_ANGLES - 1);
        x0    = $urandom_range(0, IMG_W - 1);
        y0    = $urandom_range(0, IMG_H - 1);
        npts  = $urandom_range(4, 12);
        pitch = $urandom_range(1, 6);
        c     = $cos(deg * PI / 180.0);
        s     = $sin(deg * PI / 180.0);
        for (int k = 0; k < npts; k++) begin
            t  = (k - npts / 2) * pitch;
            px = x0 - int'(t * s);
            py = y0 + int'(t * c);
            if (px >= 0 && px < IMG_W && py >= 0 && py < IMG_H)
                queue_vote(px, py);
        end
        rho = x0 * c + y0 * s;
        queue_query(deg / REGION_ANGLES, (int'(rho) + RHO_HALF) / REGION_BINS);
    endtask

    // The same pixel several times: equal counts across many angles, which
    // exercises the first-strict-maximum rule.
    task automatic queue_pixel_repeat();
        int px;
        int py;
        int reps;
        px   = $urandom_range(0, IMG_W - 1);
        py   = $urandom_range(0, IMG_H - 1);
        reps = $urandom_range(2, 8);
        repeat (reps)
            queue_vote(px, py);
        queue_query($urandom_range(0, 17), (px + RHO_HALF) / REGION_BINS);
    endtask

    // Mostly well-formed bursts; the rest is scattered votes (some outside the
    // image), queries anywhere in the field ranges and the unused op.
    task automatic queue_random_phase(input int count);
        int target;
        int pick;
        target = items_queued + count;
        while (items_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_line_burst();
            else if (pick < 65)
                queue_pixel_repeat();
            else if (pick < 85)
                queue_item(random_item(OP_VOTE));
            else if (pick < 95)
                queue_item(random_item(OP_QUERY));
            else
                queue_item(random_item(t_op'(OP_UNUSED)));
        end
    endtask

    // Waits until every queued item is taken and every expected peak has come,
    // then gives a trailing vote time to finish before the block counts as idle.
    task automatic wait_for_idle();
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (VOTE_SETTLE)
            @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset threshold. The block clears its memory
        // after reset, so the first items wait out that sweep.
        queue_query(0, 0);                 // empty accumulator
        queue_query(31, 15);               // region wholly outside both ranges
        queue_vote(0, 0);                  // rho 0 at every angle
        queue_vote(0, 0);                  // equal counts across all angles
        queue_vote(IMG_W - 1, IMG_H - 1);
        queue_vote(IMG_W - 1, 0);
        queue_vote(0, IMG_H - 1);
        queue_vote(IMG_W, 5);              // pixel right of the image
        queue_vote(5, IMG_H);              // pixel below the image
        queue_vote(1023, 511);             // both coordinates at their field maximum
        queue_item(random_item(t_op'(OP_UNUSED)));
        queue_query(0, 5);                 // rho 0 bin, angle 0 has the most votes and wins
        queue_query(17, 5);                // last angle region
        queue_query(17, 11);               // rho region clipped at the top bin
        queue_query(18, 0);                // angles past the last one
        queue_query(4, 9);                 // far corner near 45 degrees
        queue_query(0, 8);                 // right edge pixel at angle 0
        queue_query(9, 9);
        queue_item(random_item(OP_CLEAR));
        queue_query(4, 9);                 // everything gone after the clear
        queue_query(0, 5);
        wait_for_idle();

        // Random phases under different thresholds, including both extremes.
        write_threshold('0);
        queue_random_phase(180);
        wait_for_idle();

        write_threshold(THRESH_TOP);
        queue_random_phase(180);
        wait_for_idle();

        write_threshold(COUNT_W'($urandom_range(2, 12)));
        queue_random_phase(180);
        wait_for_idle();

        write_threshold(COUNT_W'($urandom_range(13, 40)));
        queue_random_phase(180);
        wait_for_idle();

        repeat (END_SETTLE)
            @(posedge clk);

        if (bad_results == 0 && expected_peaks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
